### hw/rtl/tte_pkg.sv
// ----------------------------------------------------------------------------
// tte_pkg: shared types and constants of the tap tempo estimator
// Field widths, register reset values, register indexes and tap result codes.
// ----------------------------------------------------------------------------
package tte_pkg;

    // Field widths
    localparam int LED_ON_W  = 8;
    localparam int MAX_INT_W = 12;
    localparam int LOCKOUT_W = 8;
    localparam int BPM_W     = 16;
    localparam int PERIOD_W  = 12;
    localparam int RESULT_W  = 2;

    // Parameter defaults and fixed constants
    localparam int SAMPLES_DEF   = 4;
    localparam int TIME_BITS_DEF = 32;
    localparam int BOOT_PERIOD   = 1000;
    localparam int BPM_SCALE     = 60000;

    // Register reset values
    localparam logic [LED_ON_W-1:0]  LED_ON_RST  = LED_ON_W'(50);
    localparam logic [MAX_INT_W-1:0] MAX_INT_RST = MAX_INT_W'(1500);
    localparam logic [LOCKOUT_W-1:0] LOCKOUT_RST = LOCKOUT_W'(50);

    // Configuration port
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 4;
    localparam int REG_IDX_LSB = 2;
    localparam int REG_IDX_W   = APB_ADDR_W - REG_IDX_LSB;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_LED_ON,
        REG_MAX_INTERVAL,
        REG_LOCKOUT
    } t_reg_index;

    typedef enum logic [RESULT_W-1:0] {
        TAP_NONE,
        TAP_ACCEPTED,
        TAP_RESTART,
        TAP_LOCKED
    } t_tap_result;

endpackage

### hw/rtl/tte_div.sv
// ----------------------------------------------------------------------------
// tte_div: bit-serial restoring divider
// Shifts one numerator bit out and one quotient bit in per cycle while busy.
// ----------------------------------------------------------------------------
module tte_div
    import tte_pkg::*;
#(
    parameter int NUM_W = 19,
    parameter int DEN_W = 15
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quo;   // numerator bits shift out, quotient bits shift in

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W+1:0] diff;
    logic             fits;

    always_comb begin
        rem_sh = {r_rem, r_quo[NUM_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_den};
        fits   = !diff[DEN_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quo  <= i_num;
            end else if (r_busy) begin
                // Subtract when the partial remainder fits, else restore
                r_rem <= fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], fits};
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

### hw/rtl/tap_tempo_estimator.sv
// ----------------------------------------------------------------------------
// tap_tempo_estimator: tap tempo averaging with a beat LED
// Turns millisecond ticks with press flags into a beat period, BPM and LED.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall / i_tap): one item per millisecond tick,
//   i_tap high when a debounced press edge happened in that tick.
//   Output channel (o_valid / i_stall / o_led, o_bpm, o_beat_period,
//   o_tap_result): exactly one result item per input item, in order.
//   APB port: led_on_time at 0x0, max_interval at 0x4, lockout_time at 0x8.
//   Write registers only while the block is idle.
// Timing:
//   A tick without an accepted tap goes from S_IDLE through S_OUT to the result.
//   A tick with an accepted tap runs two divisions (mean period, then BPM)
//   on one bit-serial divider, one quotient bit per cycle; NUM_W is 19
//   with 4 samples. The divider sets the rate; one tick is in flight at a
//   time.
// Reset: synchronous, active low. Registers return to 50/1500/50, period
//   to 1000 ms, tempo to 60 BPM, the interval history empties, and the LED
//   lights on the first tick.
// Stall: a finished result waits in the output register while i_stall is
//   high; the next tick is still accepted and is held at the output stage
//   until the register frees up.
// ----------------------------------------------------------------------------
module tap_tempo_estimator
    import tte_pkg::*;
#(
    parameter int SAMPLES   = SAMPLES_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Tick input channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_tap,
    // Result output channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_led,
    output logic [BPM_W-1:0]      o_bpm,
    output logic [PERIOD_W-1:0]   o_beat_period,
    output logic [RESULT_W-1:0]   o_tap_result,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CNT_W      = $clog2(SAMPLES + 1);
    localparam int SLOT_W     = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int SUM_W      = PERIOD_W + CNT_W;
    localparam int BPM_X2     = 2 * BPM_SCALE;
    localparam int NUM_W      = $clog2(BPM_X2 * SAMPLES + SAMPLES * ((1 << PERIOD_W) - 1) + 1);
    localparam int DEN_W      = SUM_W + 1;
    localparam int BOOT_TEMPO = BPM_SCALE / BOOT_PERIOD;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PER_START,
        S_PER_WAIT,
        S_BPM_START,
        S_BPM_WAIT,
        S_OUT
    } t_state;

    t_state r_state;

    // Configuration registers
    logic [LED_ON_W-1:0]  r_led_on;
    logic [MAX_INT_W-1:0] r_max_int;
    logic [LOCKOUT_W-1:0] r_lockout;

    // Tick state. Ages count ms since the last handled press and since the
    // current period start; both wrap at TIME_BITS bits.
    logic [TIME_BITS-1:0] r_age_press;
    logic [TIME_BITS-1:0] r_age_blink;
    logic                 r_pending;
    logic                 r_led;
    logic [PERIOD_W-1:0]  r_period;
    logic [BPM_W-1:0]     r_tempo;
    t_tap_result          r_result;

    // Interval history: running sum and fill count stand in for the ring scan
    logic [PERIOD_W-1:0]  r_ring [SAMPLES];
    logic [SLOT_W-1:0]    r_slot;
    logic [CNT_W-1:0]     r_count;
    logic [SUM_W-1:0]     r_sum;

    // Output register
    logic                 r_out_valid;
    logic                 r_out_led;
    logic [BPM_W-1:0]     r_out_bpm;
    logic [PERIOD_W-1:0]  r_out_period;
    logic [RESULT_W-1:0]  r_out_result;

    // Tick decisions
    logic                 accept;
    logic                 cfg_wr;
    logic                 led_done;
    logic                 per_done;
    logic                 past_lock;
    logic                 is_short;
    logic                 handled;
    logic                 store;
    logic                 blink_restart;
    logic                 n_led;
    logic                 n_pending;
    t_tap_result          n_result;
    logic [TIME_BITS-1:0] n_age_press;
    logic [TIME_BITS-1:0] n_age_blink;
    logic [PERIOD_W-1:0]  interval;
    logic [PERIOD_W-1:0]  old_entry;
    logic [SUM_W-1:0]     n_sum;
    logic [CNT_W-1:0]     n_count;
    logic [SLOT_W-1:0]    n_slot;

    // Divider hookup
    logic                 div_start;
    logic [NUM_W-1:0]     div_num;
    logic [DEN_W-1:0]     div_den;
    logic                 div_done;
    logic [NUM_W-1:0]     div_quot;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    // Register readback
    always_comb begin
        unique case (paddr[APB_ADDR_W-1:REG_IDX_LSB])
            REG_LED_ON:       prdata = APB_DATA_W'(r_led_on);
            REG_MAX_INTERVAL: prdata = APB_DATA_W'(r_max_int);
            REG_LOCKOUT:      prdata = APB_DATA_W'(r_lockout);
            default:          prdata = '0;
        endcase
    end

    // Beat LED step, then press handling, for the tick being accepted
    always_comb begin
        led_done  = r_age_blink >= TIME_BITS'(r_led_on);
        per_done  = r_age_blink >= TIME_BITS'(r_period);
        past_lock = r_age_press > TIME_BITS'(r_lockout);
        is_short  = r_age_press < TIME_BITS'(r_max_int);
        handled   = i_tap && past_lock;
        store     = handled && is_short;
        interval  = r_age_press[PERIOD_W-1:0];

        // LED: light on a pending start, darken after the on time, and
        // request the next start once the full period has elapsed.
        n_led         = r_led;
        n_pending     = r_pending;
        blink_restart = 1'b0;
        if (r_pending) begin
            n_led     = 1'b1;
            n_pending = 1'b0;
        end else if (led_done) begin
            n_led = 1'b0;
            if (per_done) begin
                blink_restart = 1'b1;
                n_pending     = 1'b1;
            end
        end
        if (store) begin
            n_pending = 1'b1;
        end

        priority if (!i_tap) begin
            n_result = TAP_NONE;
        end else if (!past_lock) begin
            n_result = TAP_LOCKED;
        end else if (is_short) begin
            n_result = TAP_ACCEPTED;
        end else begin
            n_result = TAP_RESTART;
        end

        // Ages advance by one after the tick; a restart of either reference
        // time means the age is one at the next tick.
        n_age_press = handled ? TIME_BITS'(1) : r_age_press + TIME_BITS'(1);
        n_age_blink = (handled || blink_restart) ? TIME_BITS'(1)
                                                 : r_age_blink + TIME_BITS'(1);

        // Entries at or above the fill count are stale and count as empty
        old_entry = (r_count == CNT_W'(SAMPLES)) ? r_ring[r_slot] : '0;
        n_sum     = r_sum - SUM_W'(old_entry) + SUM_W'(interval);
        n_count   = (r_count == CNT_W'(SAMPLES)) ? r_count : r_count + CNT_W'(1);
        n_slot    = (r_slot == SLOT_W'(SAMPLES - 1)) ? '0 : r_slot + SLOT_W'(1);
    end

    // Division operands: rounded mean (2*sum+count)/(2*count), then rounded
    // BPM (120000*count+sum)/(2*sum).
    always_comb begin
        div_start = (r_state == S_PER_START) || (r_state == S_BPM_START);
        if (r_state == S_BPM_START) begin
            div_num = NUM_W'(BPM_X2 * r_count) + NUM_W'(r_sum);
            div_den = DEN_W'({r_sum, 1'b0});
        end else begin
            div_num = NUM_W'({r_sum, 1'b0}) + NUM_W'(r_count);
            div_den = DEN_W'({r_count, 1'b0});
        end
    end

    tte_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Interval history storage
    always_ff @(posedge i_clk) begin
        if (accept && store) begin
            r_ring[r_slot] <= interval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_led_on    <= LED_ON_RST;
            r_max_int   <= MAX_INT_RST;
            r_lockout   <= LOCKOUT_RST;
            r_age_press <= '0;
            r_age_blink <= '0;
            r_pending   <= 1'b1;
            r_led       <= 1'b0;
            r_period    <= PERIOD_W'(BOOT_PERIOD);
            r_tempo     <= BPM_W'(BOOT_TEMPO);
            r_result    <= TAP_NONE;
            r_slot      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[APB_ADDR_W-1:REG_IDX_LSB])
                    REG_LED_ON:       r_led_on  <= pwdata[LED_ON_W-1:0];
                    REG_MAX_INTERVAL: r_max_int <= pwdata[MAX_INT_W-1:0];
                    REG_LOCKOUT:      r_lockout <= pwdata[LOCKOUT_W-1:0];
                    default:          ;
                endcase
            end

            // Drop the held result once the receiver takes it; the output
            // stage reloads the register itself in that case.
            if (r_out_valid && !i_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_led       <= n_led;
                        r_pending   <= n_pending;
                        r_result    <= n_result;
                        r_age_press <= n_age_press;
                        r_age_blink <= n_age_blink;
                        if (store) begin
                            r_sum   <= n_sum;
                            r_count <= n_count;
                            r_slot  <= n_slot;
                            r_state <= S_PER_START;
                        end else begin
                            if (handled) begin
                                // Too slow: empty the history and start over
                                r_sum   <= '0;
                                r_count <= '0;
                                r_slot  <= '0;
                            end
                            r_state <= S_OUT;
                        end
                    end
                end
                S_PER_START: begin
                    r_state <= S_PER_WAIT;
                end
                S_PER_WAIT: begin
                    if (div_done) begin
                        r_period <= div_quot[PERIOD_W-1:0];
                        r_state  <= S_BPM_START;
                    end
                end
                S_BPM_START: begin
                    r_state <= S_BPM_WAIT;
                end
                S_BPM_WAIT: begin
                    if (div_done) begin
                        r_tempo <= div_quot[BPM_W-1:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // Hold here until the output register is free
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_led    <= r_led;
                        r_out_bpm    <= r_tempo;
                        r_out_period <= r_period;
                        r_out_result <= r_result;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_led         = r_out_led;
    assign o_bpm         = r_out_bpm;
    assign o_beat_period = r_out_period;
    assign o_tap_result  = r_out_result;

endmodule

### hw/rtl/tte_chk.sv
// ----------------------------------------------------------------------------
// tte_chk: port-level checks for the tap tempo estimator
// Watches the top-level ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module tte_chk
    import tte_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic                  o_led,
    input logic [BPM_W-1:0]      o_bpm,
    input logic [PERIOD_W-1:0]   o_beat_period,
    input logic [RESULT_W-1:0]   o_tap_result
);

    // Reset leaves no result pending and the input side open
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("result or stall survived reset");

    // A tick is worked on alone: the input side closes right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("second tick taken while one is in flight");

    // Period and tempo never leave their nonzero ranges
    a_nonzero_tempo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_bpm != '0) && (o_beat_period != '0))
        else $error("zero tempo or period on output");

    // A stalled result stays put
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid && $stable(o_bpm) && $stable(o_beat_period)
            && $stable(o_tap_result) && $stable(o_led))
        else $error("stalled result changed");

endmodule

bind tap_tempo_estimator tte_chk u_tte_chk (.*);
